// ===== rtl/lcwc_pkg.sv =====
// shared types and constants for the load cell weight calibration block
package lcwc_pkg;

  localparam int CHANNELS = 2;
  localparam int QDEPTH   = 2;
  localparam int CFG_AW   = 4;

  // floor(x / 1000) == (x * WEIGHT_RECIP) >> WEIGHT_SHIFT for any 32-bit x
  localparam logic [28:0] WEIGHT_RECIP = 29'd274877907;
  localparam int          WEIGHT_SHIFT = 38;
  localparam logic [31:0] MASS_MUL     = 32'd1000;

  typedef enum logic [1:0] {
    REG_MASS   = 2'd0,
    REG_CAL_CH = 2'd1,
    REG_ROLL   = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_NOLOAD = 2'd1,
    REQ_LOADED = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_RECIP,
    ST_DIV,
    ST_QUOT,
    ST_OFFSET,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] mass;
    logic        cal_ch;
    logic [15:0] roll;
  } cfg_t;

  typedef struct packed {
    req_e        kind;
    logic        ch;
    logic [15:0] raw;
  } entry_t;

  typedef struct packed {
    logic        ch;
    logic [15:0] raw;
    logic [15:0] weight;
    logic [15:0] fil;
    logic        done;
    logic        err;
  } result_t;

endpackage

// ===== rtl/lcwc_front.sv =====
// front end: accepts requests, classifies them and assigns the sample channel
module lcwc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  input  logic [23:0]     adc_word_i,
  input  lcwc_pkg::cfg_t  cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output lcwc_pkg::entry_t entry_o
);
  import lcwc_pkg::*;

  logic cur_ch_q, cur_ch_d;
  req_e kind;

  assign kind       = req_e'(req_type_i);
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.kind = kind;
    entry_o.ch   = 1'b0;
    entry_o.raw  = '0;
    case (kind)
      REQ_SAMPLE: begin
        entry_o.ch  = cur_ch_q;
        entry_o.raw = adc_word_i[23:8];
      end
      REQ_NOLOAD, REQ_LOADED: begin
        entry_o.ch = cfg_i.cal_ch;
      end
      default: begin
        entry_o.kind = REQ_UNUSED;
      end
    endcase
  end

  assign cur_ch_d = (push_o && kind == REQ_SAMPLE) ? ~cur_ch_q : cur_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ch_q <= 1'b0;
    end else begin
      cur_ch_q <= cur_ch_d;
    end
  end

endmodule

// ===== rtl/lcwc_fifo.sv =====
// short request queue between front and back end
module lcwc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lcwc_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lcwc_pkg::entry_t entry_o
);
  import lcwc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  entry_t           mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/lcwc_div.sv =====
// 32-bit unsigned restoring divider, one quotient bit per cycle
module lcwc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import lcwc_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

endmodule

// ===== rtl/lcwc_back.sv =====
// back end: weight conversion, calibration sequencer and output register
module lcwc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcwc_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  lcwc_pkg::entry_t  q_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lcwc_pkg::result_t out_o
);
  import lcwc_pkg::*;

  state_e      state_q, state_d;
  req_e        kind_q, kind_d;
  logic        ch_q, ch_d;
  logic        neg_q, neg_d;
  logic [31:0] prod_q, prod_d;
  logic [15:0] wq_q, wq_d;
  result_t     res_q, res_d, out_q, out_d;
  logic        ovalid_q, ovalid_d;

  logic [15:0] last_raw_q [CHANNELS];
  logic [15:0] last_raw_d [CHANNELS];
  logic [15:0] scale_q    [CHANNELS];
  logic [15:0] scale_d    [CHANNELS];
  logic [31:0] zoff_q     [CHANNELS];
  logic [31:0] zoff_d     [CHANNELS];
  logic [15:0] noload_q, noload_d;

  logic               div_start, div_done;
  logic [31:0]        div_dividend, div_divisor, div_quot;
  logic [15:0]        mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] mul_full;
  logic [60:0]        recip_full;
  logic [31:0]        diff, acc;
  logic [15:0]        qs;
  logic [15:0]        sel_raw;
  logic               out_free;

  assign mul_full    = $signed({1'b0, mul_a}) * mul_b;
  assign recip_full  = {29'd0, prod_q} * {32'd0, WEIGHT_RECIP};
  assign sel_raw     = last_raw_q[q_entry_i.ch];
  assign diff        = {{16{sel_raw[15]}}, sel_raw} - {{16{noload_q[15]}}, noload_q};
  assign acc         = prod_q + zoff_q[ch_q];
  assign qs          = neg_q ? (16'd0 - wq_q) : wq_q;
  assign out_free    = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  lcwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.kind)
            REQ_SAMPLE: state_d = ST_MUL;
            REQ_LOADED: state_d = (diff == '0) ? ST_OUT : ST_DIV;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = ST_RECIP;
      ST_RECIP:  state_d = ST_QUOT;
      ST_DIV:    state_d = div_done ? ST_QUOT : ST_DIV;
      ST_QUOT:   state_d = (kind_q == REQ_LOADED) ? ST_OFFSET : ST_OUT;
      ST_OFFSET: state_d = ST_OUT;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_a        = '0;
    mul_b        = '0;
    kind_d       = kind_q;
    ch_d         = ch_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    wq_d         = wq_q;
    res_d        = res_q;
    out_d        = out_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    last_raw_d   = last_raw_q;
    scale_d      = scale_q;
    zoff_d       = zoff_q;
    noload_d     = noload_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          kind_d    = q_entry_i.kind;
          ch_d      = q_entry_i.ch;
          res_d     = '0;
          res_d.ch  = q_entry_i.ch;
          case (q_entry_i.kind)
            REQ_SAMPLE: begin
              res_d.raw                     = q_entry_i.raw;
              last_raw_d[q_entry_i.ch]      = q_entry_i.raw;
            end
            REQ_NOLOAD: begin
              res_d.raw = sel_raw;
              noload_d  = sel_raw;
            end
            REQ_LOADED: begin
              res_d.raw = sel_raw;
              if (diff == '0) begin
                res_d.err = 1'b1;
              end else begin
                div_start    = 1'b1;
                div_dividend = {16'd0, cfg_i.mass} * MASS_MUL;
                div_divisor  = diff;
              end
            end
            default: begin
              res_d.ch = 1'b0;
            end
          endcase
        end
      end
      ST_MUL: begin
        mul_a  = scale_q[ch_q];
        mul_b  = res_q.raw;
        prod_d = mul_full[31:0];
      end
      ST_ADD: begin
        neg_d  = acc[31];
        prod_d = acc[31] ? (32'd0 - acc) : acc;
      end
      ST_RECIP: begin
        wq_d = recip_full[WEIGHT_SHIFT +: 16];
      end
      ST_QUOT: begin
        if (kind_q == REQ_LOADED) begin
          scale_d[ch_q] = div_quot[15:0];
          res_d.done    = 1'b1;
          mul_a         = div_quot[15:0];
          mul_b         = noload_q;
          prod_d        = mul_full[31:0];
        end else begin
          res_d.weight = qs;
          res_d.fil    = qs - cfg_i.roll;
        end
      end
      ST_OFFSET: begin
        zoff_d[ch_q] = 32'd0 - prod_q;
      end
      ST_OUT: begin
        if (out_free) begin
          out_d    = res_q;
          ovalid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ovalid_q   <= 1'b0;
      noload_q   <= '0;
      last_raw_q <= '{default: '0};
      scale_q    <= '{default: '0};
      zoff_q     <= '{default: '0};
    end else begin
      state_q    <= state_d;
      ovalid_q   <= ovalid_d;
      noload_q   <= noload_d;
      last_raw_q <= last_raw_d;
      scale_q    <= scale_d;
      zoff_q     <= zoff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ch_q   <= ch_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    wq_q   <= wq_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

// ===== rtl/load_cell_weight_calibration.sv =====
// top level of the two-channel load cell weight converter with calibration
//
// requests enter on the in channel (req_type_i, adc_word_i) with valid/ready;
// one result per request leaves on the out channel, in request order
// sample requests go to channels 0 and 1 in turn; calibration requests use
// the channel in the cal_channel register
// registers on the apb port: 0 calibration_mass, 4 cal_channel, 8 roll_weight
// a front end classifies each transaction into a two-entry queue; the back end
// runs them one at a time through a multiplier, a reciprocal multiply for the
// division by 1000 and a 32-bit divider for the calibration scale
// a sample runs through multiply, add, reciprocal and quotient; a loaded-code
// request waits on the 32 steps of the divider; others go straight to output
// while the back end works, up to two more requests are queued
// a result waits in the output register while the receiver stalls; the back
// end then holds its next result and the queue fills before in_ready_o drops
// reset clears the registers, channel, raw codes and calibration constants
module load_cell_weight_calibration (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [lcwc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [23:0]           adc_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  channel_o,
  output logic signed [15:0]    raw_code_o,
  output logic [15:0]           weight_o,
  output logic [15:0]           filament_weight_o,
  output logic                  calib_done_o,
  output logic                  calib_error_o
);
  import lcwc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  reg_e    reg_sel;
  logic    cfg_wr;
  logic    push, full, pop, q_valid;
  entry_t  push_entry, q_entry;
  result_t result;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_MASS:   cfg_d.mass   = pwdata[15:0];
        REG_CAL_CH: cfg_d.cal_ch = pwdata[0];
        REG_ROLL:   cfg_d.roll   = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MASS:   prdata = {16'd0, cfg_q.mass};
      REG_CAL_CH: prdata = {31'd0, cfg_q.cal_ch};
      REG_ROLL:   prdata = {16'd0, cfg_q.roll};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lcwc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .adc_word_i (adc_word_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  lcwc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  lcwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (result)
  );

  assign channel_o         = result.ch;
  assign raw_code_o        = result.raw;
  assign weight_o          = result.weight;
  assign filament_weight_o = result.fil;
  assign calib_done_o      = result.done;
  assign calib_error_o     = result.err;

endmodule
